// ----- hdl/tct_pkg.sv -----
package tct_pkg;

  // One source byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
  } src_t;

  // One token as it leaves on the output channel.
  typedef struct packed {
    logic [4:0]         token_kind;
    logic signed [31:0] token_value;
    logic               run_done;
    logic               stream_done;
  } token_t;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_SYM
  } cls_t;

  // A classified byte, passed from the front end to the scanner.
  typedef struct packed {
    cls_t       cls;
    logic [4:0] sym_kind;
    logic [3:0] dval;
    logic [7:0] ch;
    logic       fin;
  } cmd_t;

  // Token kinds beyond the nine symbols, whose kinds are their table positions.
  localparam logic [4:0] KIND_IF    = 5'd9;
  localparam logic [4:0] KIND_ELSE  = 5'd10;
  localparam logic [4:0] KIND_DO    = 5'd11;
  localparam logic [4:0] KIND_WHILE = 5'd12;
  localparam logic [4:0] KIND_NUM   = 5'd13;
  localparam logic [4:0] KIND_VAR   = 5'd14;
  localparam logic [4:0] KIND_END   = 5'd15;
  localparam logic [4:0] KIND_ERR   = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ----- hdl/tct_front.sv -----
module tct_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  tct_pkg::src_t   src_data,
  input  logic            q_full,
  output logic            q_push,
  output tct_pkg::cmd_t   q_data
);

  localparam int unsigned NUM_SYMS = 9;
  localparam logic [7:0] SYM_CHARS [NUM_SYMS] = '{"{", "}", "=", ";", "(", ")", "+", "-", "<"};

  logic          f_valid;
  tct_pkg::cmd_t cls_cmd;
  logic          load;

  always_comb begin
    logic [7:0] c;
    c = src_data.char_byte;
    cls_cmd.cls      = tct_pkg::CLS_OTHER;
    cls_cmd.sym_kind = '0;
    cls_cmd.dval     = c[3:0];
    cls_cmd.ch       = c;
    cls_cmd.fin      = src_data.final_byte;
    if (c >= "0" && c <= "9") begin
      cls_cmd.cls = tct_pkg::CLS_DIGIT;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      cls_cmd.cls = tct_pkg::CLS_LETTER;
    end else begin
      for (int i = 0; i < NUM_SYMS; i++) begin
        if (c == SYM_CHARS[i]) begin
          cls_cmd.cls      = tct_pkg::CLS_SYM;
          cls_cmd.sym_kind = 5'(i);
        end
      end
    end
  end

  // The stage reloads whenever it is empty or its content moves into the queue.
  assign load      = !f_valid || !q_full;
  assign src_stall = f_valid && q_full;
  assign q_push    = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_data <= cls_cmd;
    end
  end

endmodule

// ----- hdl/tct_queue.sv -----
module tct_queue #(
  parameter int unsigned DEPTH = tct_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tct_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output tct_pkg::cmd_t head,
  output logic          empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tct_pkg::cmd_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

// ----- hdl/tct_back.sv -----
module tct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  tct_pkg::cmd_t    q_head,
  output logic             q_pop,
  output logic             tok_valid,
  input  logic             tok_stall,
  output tct_pkg::token_t  tok_data
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_ERR
  } mode_t;

  localparam int unsigned WORD_DEPTH = 5;
  localparam logic [2:0]  WORD_OVER  = 3'd6;
  localparam int unsigned MAX_TOKS   = 3;

  localparam logic [4:0] KIND_IF    = tct_pkg::KIND_IF;
  localparam logic [4:0] KIND_ELSE  = tct_pkg::KIND_ELSE;
  localparam logic [4:0] KIND_DO    = tct_pkg::KIND_DO;
  localparam logic [4:0] KIND_WHILE = tct_pkg::KIND_WHILE;
  localparam logic [4:0] KIND_NUM   = tct_pkg::KIND_NUM;
  localparam logic [4:0] KIND_VAR   = tct_pkg::KIND_VAR;
  localparam logic [4:0] KIND_END   = tct_pkg::KIND_END;
  localparam logic [4:0] KIND_ERR   = tct_pkg::KIND_ERR;

  localparam logic [30:0]        NUM_MAX  = 31'h7FFF_FFFF;
  localparam logic signed [31:0] NO_VALUE = -32'sd1;
  localparam logic [7:0]         CHAR_A   = "a";

  // acc * 10 + d, saturating at the largest positive 32-bit value.
  function automatic logic [30:0] num_step(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
    return (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[30:0];
  endfunction

  function automatic logic [4:0] word_kind(input logic [4:0][7:0] w, input logic [2:0] len);
    logic [4:0] k;
    k = KIND_ERR;
    if (len == 3'd1) begin
      k = KIND_VAR;
    end else if (len == 3'd2 && w[0] == "i" && w[1] == "f") begin
      k = KIND_IF;
    end else if (len == 3'd2 && w[0] == "d" && w[1] == "o") begin
      k = KIND_DO;
    end else if (len == 3'd4 && w[0] == "e" && w[1] == "l" && w[2] == "s" && w[3] == "e") begin
      k = KIND_ELSE;
    end else if (len == 3'd5 && w[0] == "w" && w[1] == "h" && w[2] == "i" && w[3] == "l"
                 && w[4] == "e") begin
      k = KIND_WHILE;
    end
    return k;
  endfunction

  function automatic logic signed [31:0] var_value(input logic [7:0] c);
    return $signed({24'd0, c} - {24'd0, CHAR_A});
  endfunction

  function automatic tct_pkg::token_t mk_tok(input logic [4:0] kind,
                                             input logic signed [31:0] value,
                                             input logic sdone);
    tct_pkg::token_t t;
    t.token_kind  = kind;
    t.token_value = value;
    t.run_done    = 1'b0;
    t.stream_done = sdone;
    return t;
  endfunction

  mode_t                  mode;
  mode_t                  mode_next;
  logic [30:0]            acc;
  logic [30:0]            acc_next;
  logic [2:0]             len;
  logic [2:0]             len_next;
  logic [4:0][7:0]        letters;
  logic                   let_we;
  logic [2:0]             let_idx;
  tct_pkg::token_t        b_tok [MAX_TOKS];
  tct_pkg::token_t        nb_tok [MAX_TOKS];
  logic [1:0]             b_cnt;
  logic [1:0]             nb_cnt;
  logic                   out_free;

  assign out_free = !tok_valid || !tok_stall;
  // A new byte is taken once the tokens of the previous one are all handed on.
  assign q_pop = !q_empty && (b_cnt == 2'd0 || (b_cnt == 2'd1 && out_free));

  always_comb begin
    mode_t           m;
    tct_pkg::cls_t   cls;
    logic            stop;
    logic [30:0]     a;
    logic [2:0]      l;
    logic [4:0]      k;
    logic [4:0][7:0] view;
    logic [1:0]      n;

    m        = mode;
    cls      = q_head.cls;
    stop     = 1'b0;
    a        = acc;
    l        = len;
    k        = KIND_ERR;
    view     = letters;
    n        = 2'd0;
    mode_next = mode;
    acc_next  = acc;
    len_next  = len;
    let_we    = 1'b0;
    let_idx   = len;
    for (int i = 0; i < MAX_TOKS; i++) begin
      nb_tok[i] = mk_tok(KIND_END, NO_VALUE, 1'b0);
    end

    if (mode == MODE_ERR) begin
      // Everything up to the final byte is swallowed.
      if (q_head.fin) begin
        mode_next = MODE_IDLE;
      end
    end else begin
      if (m == MODE_NUM && (cls != tct_pkg::CLS_DIGIT || q_head.fin)) begin
        if (cls == tct_pkg::CLS_DIGIT) begin
          a   = num_step(acc, q_head.dval);
          cls = tct_pkg::CLS_OTHER;
        end
        nb_tok[n] = mk_tok(KIND_NUM, $signed({1'b0, a}), 1'b0);
        n = n + 1'b1;
        m = MODE_IDLE;
      end
      if (m == MODE_WORD && (cls != tct_pkg::CLS_LETTER || q_head.fin)) begin
        if (cls == tct_pkg::CLS_LETTER) begin
          if (len < 3'(WORD_DEPTH)) begin
            view[len] = q_head.ch;
            l = len + 1'b1;
          end else begin
            l = WORD_OVER;
          end
          cls = tct_pkg::CLS_OTHER;
        end
        k = word_kind(view, l);
        m = MODE_IDLE;
        if (k == KIND_ERR) begin
          nb_tok[n] = mk_tok(KIND_ERR, NO_VALUE, 1'b1);
          n = n + 1'b1;
          m = q_head.fin ? MODE_IDLE : MODE_ERR;
          stop = 1'b1;
        end else begin
          nb_tok[n] = mk_tok(k, (k == KIND_VAR) ? var_value(view[0]) : NO_VALUE, 1'b0);
          n = n + 1'b1;
        end
      end
      if (!stop) begin
        if (cls == tct_pkg::CLS_SYM) begin
          nb_tok[n] = mk_tok(q_head.sym_kind, NO_VALUE, 1'b0);
          n = n + 1'b1;
        end
        if (cls == tct_pkg::CLS_DIGIT) begin
          a = num_step((m == MODE_NUM) ? acc : 31'd0, q_head.dval);
          acc_next = a;
          m = MODE_NUM;
          if (q_head.fin) begin
            nb_tok[n] = mk_tok(KIND_NUM, $signed({1'b0, a}), 1'b0);
            n = n + 1'b1;
            m = MODE_IDLE;
          end
        end
        if (cls == tct_pkg::CLS_LETTER) begin
          l = (m == MODE_WORD) ? len : 3'd0;
          if (l < 3'(WORD_DEPTH)) begin
            let_we   = 1'b1;
            let_idx  = l;
            len_next = l + 1'b1;
          end else begin
            len_next = WORD_OVER;
          end
          m = MODE_WORD;
          // A word that opens on the final byte has one letter, so it is a variable.
          if (q_head.fin) begin
            nb_tok[n] = mk_tok(KIND_VAR, var_value(q_head.ch), 1'b0);
            n = n + 1'b1;
            m = MODE_IDLE;
          end
        end
        if (q_head.fin) begin
          nb_tok[n] = mk_tok(KIND_END, NO_VALUE, 1'b1);
          n = n + 1'b1;
          m = MODE_IDLE;
        end
      end
      mode_next = m;
    end

    if (n != 2'd0) begin
      nb_tok[n - 1'b1].run_done = 1'b1;
    end
    nb_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      acc       <= '0;
      len       <= '0;
      b_cnt     <= '0;
      tok_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        mode <= mode_next;
        acc  <= acc_next;
        len  <= len_next;
      end
      if (out_free) begin
        tok_valid <= (b_cnt != 2'd0);
      end
      if (q_pop) begin
        b_cnt <= nb_cnt;
      end else if (out_free && b_cnt != 2'd0) begin
        b_cnt <= b_cnt - 1'b1;
      end
    end
    if (q_pop && let_we) begin
      letters[let_idx] <= q_head.ch;
    end
    // Pending tokens shift toward the output register one per transfer.
    if (out_free && b_cnt != 2'd0) begin
      tok_data <= b_tok[0];
    end
    if (q_pop) begin
      b_tok <= nb_tok;
    end else if (out_free && b_cnt != 2'd0) begin
      b_tok[0] <= b_tok[1];
      b_tok[1] <= b_tok[2];
    end
  end

`ifndef SYNTH
  a_close_is_last: assert property (@(posedge clk) disable iff (rst)
      tok_valid && tok_data.stream_done |-> tok_data.run_done)
    else $error("closing token is not the last of its byte");
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
      q_pop && mode == MODE_ERR |-> nb_cnt == 2'd0)
    else $error("token produced while swallowing after an error");
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
      tok_valid && tok_data.token_kind == KIND_END |-> tok_data.stream_done)
    else $error("end token without stream_done");
`endif

endmodule

// ----- hdl/tiny_c_tokenizer.sv -----
// Byte-stream lexer for a tiny C-like language.
// The src channel takes one source byte per transfer (char_byte, with final_byte
// marking the last byte of a text); the tok channel gives tokens, each with its
// kind, value, run_done on the last token a byte causes and stream_done on the
// end or error token that closes a text. A byte causes zero to three tokens.
// A byte passes a classifying front stage and a command queue of QUEUE_DEPTH
// entries, then the scanner, which keeps the pending number or word and builds
// all of that byte's tokens together; an output register hands them out one
// per transfer. A byte's first token passes the front register, the queue,
// the scanner's token buffer and the output register. Bytes go in at one per
// cycle while each causes at most one token and tok does not stall; a byte with
// more holds the scanner while its tokens pass the single output register.
// A stall on tok holds the output register; the queue then fills and src_stall
// rises. Reset empties the stages and the queue and returns the scanner to
// idle with the number cleared; no token is pending after reset.
module tiny_c_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = tct_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  tct_pkg::src_t   src_data,
  output logic            tok_valid,
  input  logic            tok_stall,
  output tct_pkg::token_t tok_data
);

  logic          q_full;
  logic          q_push;
  tct_pkg::cmd_t q_data;
  logic          q_pop;
  logic          q_empty;
  tct_pkg::cmd_t q_head;

  tct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  tct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  tct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

endmodule
